FILE: rtl/rbos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbos_pkg: shared types and constants for the rollback offset smoother
// Field widths, offset format, control register indexes and the structs
// passed between the control registers, the datapath and the top level.
// ----------------------------------------------------------------------------
package rbos_pkg;

   // Tracked objects and offset format
   localparam int NUM_OBJECTS = 2;
   localparam int FRAC_BITS   = 8;

   localparam int POS_W  = 16;
   localparam int OFF_W  = 18;
   localparam int KEEP_W = 16;
   localparam int SNAP_W = 15;
   localparam int ZERO_W = 16;

   // Derived datapath widths
   localparam int DIFF_W  = POS_W + 1;
   localparam int SQ_W    = 2 * POS_W;
   localparam int M2_W    = SQ_W + 1;
   localparam int SNSQ_W  = 2 * SNAP_W;
   localparam int SEED_W  = DIFF_W + FRAC_BITS;
   localparam int CMP_W   = ((POS_W + FRAC_BITS > OFF_W) ? POS_W + FRAC_BITS : OFF_W) + 1;

   // Control register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(39322);
   localparam logic [SNAP_W-1:0] SNAP_RESET = SNAP_W'(150);
   localparam logic [ZERO_W-1:0] ZERO_RESET = ZERO_W'(128);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEEP_FACTOR    = 2'd0,
      CSR_SNAP_THRESHOLD = 2'd1,
      CSR_ZERO_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [KEEP_W-1:0] keep_factor;
      logic [SNSQ_W-1:0] snap_sq;
      logic [ZERO_W-1:0] zero_threshold;
   } csr_type;

   typedef struct packed {
      logic                    object_index;
      logic signed [POS_W-1:0] sim_x;
      logic signed [POS_W-1:0] sim_y;
      logic                    correction_done;
      logic                    active;
   } item_type;

   typedef struct packed {
      logic signed [OFF_W-1:0] offset_h;
      logic signed [OFF_W-1:0] offset_v;
      logic signed [POS_W-1:0] shown_x;
      logic signed [POS_W-1:0] shown_y;
      logic                    started;
   } obj_state_type;

   typedef struct packed {
      logic signed [POS_W-1:0] screen_x;
      logic signed [POS_W-1:0] screen_y;
      logic                    smoothing_on;
   } result_type;

endpackage

FILE: rtl/rbos_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbos_csr: control registers
// Holds keep factor, snap threshold and zero threshold, and provides the
// squared snap threshold for the correction compare.
// ----------------------------------------------------------------------------
module rbos_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [rbos_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbos_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output rbos_pkg::csr_type                csr
);
   import rbos_pkg::*;

   logic [KEEP_W-1:0] keep_ff;
   logic [SNAP_W-1:0] snap_ff;
   logic [ZERO_W-1:0] zero_ff;

   // Register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= KEEP_RESET;
         snap_ff <= SNAP_RESET;
         zero_ff <= ZERO_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_KEEP_FACTOR:    keep_ff <= csr_write_data[KEEP_W-1:0];
            CSR_SNAP_THRESHOLD: snap_ff <= csr_write_data[SNAP_W-1:0];
            CSR_ZERO_THRESHOLD: zero_ff <= csr_write_data[ZERO_W-1:0];
            default: ;
         endcase
      end
   end

   // Outputs, snap threshold squared alongside
   always_comb begin
      csr.keep_factor    = keep_ff;
      csr.snap_sq        = SNSQ_W'(snap_ff) * SNSQ_W'(snap_ff);
      csr.zero_threshold = zero_ff;
   end

endmodule

FILE: rtl/rbos_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbos_datapath: per-request offset update
// For a started active object: seeds, snaps or decays its offset, zeroes
// small components and composes the shown position with clamping.
// ----------------------------------------------------------------------------
module rbos_datapath (
   input  rbos_pkg::item_type       item,
   input  rbos_pkg::obj_state_type  cur,
   input  rbos_pkg::csr_type        csr,
   output rbos_pkg::result_type     res,
   output rbos_pkg::obj_state_type  nxt,
   output logic                     write_en
);
   import rbos_pkg::*;

   localparam logic signed [SEED_W-1:0] SEED_MAX  = SEED_W'(2 ** (OFF_W - 1) - 1);
   localparam logic signed [SEED_W-1:0] SEED_MIN  = SEED_W'(-(2 ** (OFF_W - 1)));
   localparam logic signed [OFF_W-1:0]  OFF_MAX   = OFF_W'(2 ** (OFF_W - 1) - 1);
   localparam logic signed [OFF_W-1:0]  OFF_MIN   = OFF_W'(-(2 ** (OFF_W - 1)));
   localparam logic signed [CMP_W-1:0]  RND_BIAS  = CMP_W'(2 ** FRAC_BITS - 1);
   localparam logic signed [CMP_W-1:0]  RND_NONE  = CMP_W'(0);
   localparam logic signed [CMP_W-1:0]  POS_MAX_C = CMP_W'(2 ** (POS_W - 1) - 1);
   localparam logic signed [CMP_W-1:0]  POS_MIN_C = CMP_W'(-(2 ** (POS_W - 1)));

   // Magnitude of a position difference, always fits POS_W bits
   function automatic logic [POS_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
      logic [DIFF_W-1:0] m;
      m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      return m[POS_W-1:0];
   endfunction

   // Magnitude of an offset component
   function automatic logic [OFF_W-1:0] abs_off(input logic signed [OFF_W-1:0] o);
      return o[OFF_W-1] ? OFF_W'(-o) : OFF_W'(o);
   endfunction

   // Difference moved to fixed point, saturated to the offset range
   function automatic logic signed [OFF_W-1:0] seed_offset(
      input logic signed [DIFF_W-1:0] d);
      logic signed [SEED_W-1:0] s;
      s = signed'({d, FRAC_BITS'(0)});
      if (s > SEED_MAX)      return OFF_MAX;
      else if (s < SEED_MIN) return OFF_MIN;
      else                   return s[OFF_W-1:0];
   endfunction

   // Scale magnitude by keep factor, truncation toward zero
   function automatic logic signed [OFF_W-1:0] decay(
      input logic signed [OFF_W-1:0] o, input logic [KEEP_W-1:0] k);
      logic [OFF_W-1:0]        mag;
      logic [OFF_W+KEEP_W-1:0] prod;
      logic [OFF_W-1:0]        kept;
      mag  = abs_off(o);
      prod = (OFF_W + KEEP_W)'(mag) * (OFF_W + KEEP_W)'(k);
      kept = prod[OFF_W+KEEP_W-1:KEEP_W];
      return o[OFF_W-1] ? signed'(OFF_W'(-kept)) : signed'(kept);
   endfunction

   // Components below the zero threshold are dropped
   function automatic logic signed [OFF_W-1:0] zero_small(
      input logic signed [OFF_W-1:0] o, input logic [ZERO_W-1:0] z);
      return (abs_off(o) < OFF_W'(z)) ? OFF_W'(0) : o;
   endfunction

   // sim + offset, truncated toward zero, clamped to the position range
   function automatic logic signed [POS_W-1:0] compose(
      input logic signed [POS_W-1:0] sim, input logic signed [OFF_W-1:0] o);
      logic signed [CMP_W-1:0] v;
      logic signed [CMP_W-1:0] b;
      logic signed [CMP_W-1:0] w;
      v = (CMP_W'(sim) <<< FRAC_BITS) + CMP_W'(o);
      b = v[CMP_W-1] ? RND_BIAS : RND_NONE;
      w = (v + b) >>> FRAC_BITS;
      if (w > POS_MAX_C)      return POS_W'(POS_MAX_C);
      else if (w < POS_MIN_C) return POS_W'(POS_MIN_C);
      else                    return w[POS_W-1:0];
   endfunction

   logic                     in_range;
   logic signed [DIFF_W-1:0] dx, dy;
   logic [POS_W-1:0]         adx, ady;
   logic [SQ_W-1:0]          sqx, sqy;
   logic [M2_W-1:0]          m2;
   logic                     snap;
   logic signed [OFF_W-1:0]  ox_pre, oy_pre, ox, oy;
   logic signed [POS_W-1:0]  vx, vy;

   assign in_range = (int'(item.object_index) < NUM_OBJECTS);

   // Correction: distance between last shown and simulated position
   always_comb begin
      dx   = DIFF_W'(cur.shown_x) - DIFF_W'(item.sim_x);
      dy   = DIFF_W'(cur.shown_y) - DIFF_W'(item.sim_y);
      adx  = abs_diff(dx);
      ady  = abs_diff(dy);
      sqx  = SQ_W'(adx) * SQ_W'(adx);
      sqy  = SQ_W'(ady) * SQ_W'(ady);
      m2   = M2_W'(sqx) + M2_W'(sqy);
      snap = m2 > M2_W'(csr.snap_sq);
   end

   // New offset and composed position
   always_comb begin
      if (item.correction_done) begin
         ox_pre = snap ? OFF_W'(0) : seed_offset(dx);
         oy_pre = snap ? OFF_W'(0) : seed_offset(dy);
      end else begin
         ox_pre = decay(cur.offset_h, csr.keep_factor);
         oy_pre = decay(cur.offset_v, csr.keep_factor);
      end
      ox = zero_small(ox_pre, csr.zero_threshold);
      oy = zero_small(oy_pre, csr.zero_threshold);
      vx = compose(item.sim_x, ox);
      vy = compose(item.sim_y, oy);
   end

   // Re-anchor, first frame or smoothing update
   always_comb begin
      write_en         = in_range;
      nxt              = cur;
      res.screen_x     = item.sim_x;
      res.screen_y     = item.sim_y;
      res.smoothing_on = 1'b0;
      if (!item.active) begin
         nxt.offset_h = '0;
         nxt.offset_v = '0;
         nxt.shown_x  = item.sim_x;
         nxt.shown_y  = item.sim_y;
         nxt.started  = 1'b1;
      end else if (!cur.started) begin
         nxt.shown_x  = item.sim_x;
         nxt.shown_y  = item.sim_y;
         nxt.started  = 1'b1;
      end else begin
         nxt.offset_h     = ox;
         nxt.offset_v     = oy;
         nxt.shown_x      = vx;
         nxt.shown_y      = vy;
         res.screen_x     = vx;
         res.screen_y     = vy;
         res.smoothing_on = (ox != '0) || (oy != '0);
      end
   end

endmodule

FILE: rtl/rollback_offset_smoother.sv
`timescale 1ns / 1ps
// A request passes the input register, then the result register. Throughput:
// one request per cycle while rsp_ready holds; the per-object state is written
// as the result is registered, so back-to-back requests for one object see it.
// Reset (synchronous) empties the pipeline, clears all per-object state and
// restores the control registers to their defaults.
// ----------------------------------------------------------------------------
// rollback_offset_smoother: display offset smoother after rollback
// Input register, combinational offset update against per-object state,
// result register with valid/ready on both sides.
// ----------------------------------------------------------------------------
module rollback_offset_smoother (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [rbos_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbos_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_object_index,
   input  logic signed [rbos_pkg::POS_W-1:0] req_sim_x,
   input  logic signed [rbos_pkg::POS_W-1:0] req_sim_y,
   input  logic                             req_correction_done,
   input  logic                             req_active,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [rbos_pkg::POS_W-1:0] rsp_screen_x,
   output logic signed [rbos_pkg::POS_W-1:0] rsp_screen_y,
   output logic                             rsp_smoothing_on
);
   import rbos_pkg::*;

   csr_type       csr;
   item_type      req_item;
   item_type      s1_item_ff;
   logic          s1_valid_ff;
   logic          out_valid_ff;
   result_type    out_res_ff;
   obj_state_type state_ff [NUM_OBJECTS];
   obj_state_type cur_state;
   obj_state_type nxt_state;
   result_type    dp_res;
   logic          dp_write_en;
   logic          advance;

   rbos_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   // Handshake: result register drains, input register refills behind it
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      req_item.object_index    = req_object_index;
      req_item.sim_x           = req_sim_x;
      req_item.sim_y           = req_sim_y;
      req_item.correction_done = req_correction_done;
      req_item.active          = req_active;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_item;
      end
   end

   assign cur_state = state_ff[s1_item_ff.object_index];

   rbos_datapath u_datapath (
      .item     (s1_item_ff),
      .cur      (cur_state),
      .csr      (csr),
      .res      (dp_res),
      .nxt      (nxt_state),
      .write_en (dp_write_en)
   );

   // Per-object state, updated as the result is registered
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_OBJECTS; i++) begin
            state_ff[i] <= '0;
         end
      end else if (s1_valid_ff && advance && dp_write_en) begin
         state_ff[s1_item_ff.object_index] <= nxt_state;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && advance) begin
         out_res_ff <= dp_res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_screen_x     = out_res_ff.screen_x;
   assign rsp_screen_y     = out_res_ff.screen_y;
   assign rsp_smoothing_on = out_res_ff.smoothing_on;

   // Checks
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !s1_valid_ff))
      else $error("pipeline not empty after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("request stalled with empty result register");

   a_inactive_no_smoothing: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && !s1_item_ff.active) |=> !rsp_smoothing_on)
      else $error("smoothing reported on a re-anchor request");

   a_started_after_update: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && dp_write_en)
         |=> state_ff[$past(s1_item_ff.object_index)].started)
      else $error("object not marked started after update");

endmodule

FILE: tb/sv/smoother_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoother_scoreboard_pkg: expected-position tracking for the offset smoother
// Holds a per-object copy of the offset and last-shown state, predicts the
// displayed position for every accepted request, and compares each result
// against the oldest prediction.
// ----------------------------------------------------------------------------
package smoother_scoreboard_pkg;

   import rbos_pkg::*;

   // Offset and position limits at the block's widths
   localparam longint OFFSET_MAX = (longint'(1) <<< (OFF_W - 1)) - 1;
   localparam longint OFFSET_MIN = -(longint'(1) <<< (OFF_W - 1));
   localparam longint OFFSET_ONE = longint'(1) <<< FRAC_BITS;
   localparam longint POS_MAX    = (longint'(1) <<< (POS_W - 1)) - 1;
   localparam longint POS_MIN    = -(longint'(1) <<< (POS_W - 1));

   class smoother_scoreboard;

      // Per-object tracking state
      logic signed [OFF_W-1:0] offset_h [NUM_OBJECTS];
      logic signed [OFF_W-1:0] offset_v [NUM_OBJECTS];
      logic signed [POS_W-1:0] shown_x  [NUM_OBJECTS];
      logic signed [POS_W-1:0] shown_y  [NUM_OBJECTS];
      bit                      started  [NUM_OBJECTS];

      // Control register copies
      logic [KEEP_W-1:0] keep;
      logic [SNAP_W-1:0] snap;
      logic [ZERO_W-1:0] zero_lim;

      result_type  predicted_frames [$];
      int unsigned mismatches;

      function new();
         foreach (offset_h[i]) begin
            offset_h[i] = '0;
            offset_v[i] = '0;
            shown_x[i]  = '0;
            shown_y[i]  = '0;
            started[i]  = 1'b0;
         end
         keep       = KEEP_RESET;
         snap       = SNAP_RESET;
         zero_lim   = ZERO_RESET;
         mismatches = 0;
      endfunction

      function void set_config(logic [KEEP_W-1:0] k, logic [SNAP_W-1:0] s,
                               logic [ZERO_W-1:0] z);
         keep     = k;
         snap     = s;
         zero_lim = z;
      endfunction

      function int unsigned outstanding();
         return predicted_frames.size();
      endfunction

      function longint clip_offset(longint v);
         if (v > OFFSET_MAX) return OFFSET_MAX;
         if (v < OFFSET_MIN) return OFFSET_MIN;
         return v;
      endfunction

      // Scale magnitude by the keep factor, so it truncates toward zero
      function longint decay(longint off);
         longint mag;
         longint kept;
         mag  = (off < 0) ? -off : off;
         kept = (mag * longint'(keep)) >>> 16;
         return (off < 0) ? -kept : kept;
      endfunction

      function longint zero_small(longint off);
         longint mag;
         mag = (off < 0) ? -off : off;
         return (mag < longint'(zero_lim)) ? 0 : off;
      endfunction

      // sim + offset, truncated toward zero, clamped to the position range
      function longint compose(longint sim, longint off);
         longint v;
         longint w;
         v = sim * OFFSET_ONE + off;
         w = (v >= 0) ? (v >>> FRAC_BITS) : -((-v) >>> FRAC_BITS);
         if (w > POS_MAX) w = POS_MAX;
         if (w < POS_MIN) w = POS_MIN;
         return w;
      endfunction

      // Predict the result of one accepted request and update the state
      function void note_request(item_type rq);
         longint     sx, sy, dx, dy, ox, oy, vx, vy;
         int         o;
         result_type res;
         sx = longint'($signed(rq.sim_x));
         sy = longint'($signed(rq.sim_y));
         o  = int'(rq.object_index);
         res.screen_x     = rq.sim_x;
         res.screen_y     = rq.sim_y;
         res.smoothing_on = 1'b0;
         if (o < NUM_OBJECTS) begin
            if (!rq.active) begin
               // re-anchor to the simulated position
               offset_h[o] = '0;
               offset_v[o] = '0;
               shown_x[o]  = rq.sim_x;
               shown_y[o]  = rq.sim_y;
               started[o]  = 1'b1;
            end else if (!started[o]) begin
               // first active frame only records the position
               shown_x[o] = rq.sim_x;
               shown_y[o] = rq.sim_y;
               started[o] = 1'b1;
            end else begin
               if (rq.correction_done) begin
                  dx = longint'(shown_x[o]) - sx;
                  dy = longint'(shown_y[o]) - sy;
                  if (dx * dx + dy * dy > longint'(snap) * longint'(snap)) begin
                     ox = 0;
                     oy = 0;
                  end else begin
                     ox = clip_offset(dx * OFFSET_ONE);
                     oy = clip_offset(dy * OFFSET_ONE);
                  end
               end else begin
                  ox = decay(longint'(offset_h[o]));
                  oy = decay(longint'(offset_v[o]));
               end
               ox = zero_small(ox);
               oy = zero_small(oy);
               vx = compose(sx, ox);
               vy = compose(sy, oy);
               offset_h[o]      = OFF_W'(ox);
               offset_v[o]      = OFF_W'(oy);
               shown_x[o]       = POS_W'(vx);
               shown_y[o]       = POS_W'(vy);
               res.screen_x     = POS_W'(vx);
               res.screen_y     = POS_W'(vy);
               res.smoothing_on = (ox != 0) || (oy != 0);
            end
         end
         predicted_frames.push_back(res);
      endfunction

      // Compare one accepted result with the oldest prediction
      function void check_result(result_type got);
         result_type want;
         if (predicted_frames.size() == 0) begin
            $display("%0t: result with no request pending, screen_x %0d screen_y %0d",
                     $time, $signed(got.screen_x), $signed(got.screen_y));
            mismatches++;
            return;
         end
         want = predicted_frames.pop_front();
         if (got.screen_x !== want.screen_x) begin
            $display("%0t: screen_x mismatch, expected %0d, actual %0d",
                     $time, $signed(want.screen_x), $signed(got.screen_x));
            mismatches++;
         end
         if (got.screen_y !== want.screen_y) begin
            $display("%0t: screen_y mismatch, expected %0d, actual %0d",
                     $time, $signed(want.screen_y), $signed(got.screen_y));
            mismatches++;
         end
         if (got.smoothing_on !== want.smoothing_on) begin
            $display("%0t: smoothing_on mismatch, expected %0b, actual %0b",
                     $time, want.smoothing_on, got.smoothing_on);
            mismatches++;
         end
      endfunction

   endclass

endpackage

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: rollback offset smoother
// Directed frames for init, seeding, snap, decay, zeroing, clamping and
// saturation, then random tracking sequences over several register settings
// with random stalls on both channels and a long receiver hold.
// ----------------------------------------------------------------------------
module testbench;

   import rbos_pkg::*;
   import smoother_scoreboard_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int ITEMS_PER_PHASE  = 250;
   localparam int NUM_PHASES       = 8;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_write_data;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_object_index;
   logic signed [POS_W-1:0] req_sim_x;
   logic signed [POS_W-1:0] req_sim_y;
   logic                    req_correction_done;
   logic                    req_active;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [POS_W-1:0] rsp_screen_x;
   logic signed [POS_W-1:0] rsp_screen_y;
   logic                    rsp_smoothing_on;

   smoother_scoreboard sb;

   bit idle_on   = 1'b1;
   bit long_hold = 1'b0;
   int last_sim_x [NUM_OBJECTS];
   int last_sim_y [NUM_OBJECTS];

   rollback_offset_smoother DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_object_index    (req_object_index),
      .req_sim_x           (req_sim_x),
      .req_sim_y           (req_sim_y),
      .req_correction_done (req_correction_done),
      .req_active          (req_active),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_screen_x        (rsp_screen_x),
      .rsp_screen_y        (rsp_screen_y),
      .rsp_smoothing_on    (rsp_smoothing_on)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int clamp_pos(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic item_type frame(bit obj, int x, int y, bit corr, bit act);
      item_type rq;
      rq.object_index    = obj;
      rq.sim_x           = POS_W'(x);
      rq.sim_y           = POS_W'(y);
      rq.correction_done = corr;
      rq.active          = act;
      return rq;
   endfunction

   // Mostly smooth tracking per object with occasional rollback jumps,
   // plus re-anchors, trips to the range edges and raw noise
   function automatic item_type random_frame();
      item_type rq;
      int       o, r, span, nx, ny;
      o = $urandom_range(0, NUM_OBJECTS - 1);
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: span = 4;
         6, 7:             span = 64;
         8:                span = 600;
         default:          span = 4000;
      endcase
      nx = clamp_pos(last_sim_x[o] + int'($urandom_range(0, 2 * span)) - span);
      ny = clamp_pos(last_sim_y[o] + int'($urandom_range(0, 2 * span)) - span);
      if (r < 6) begin
         rq                 = frame(o[0], 0, 0, 1'b0, 1'b0);
         rq.sim_x           = POS_W'($urandom);
         rq.sim_y           = POS_W'($urandom);
         rq.correction_done = 1'($urandom_range(0, 1));
         rq.active          = 1'($urandom_range(0, 1));
      end else if (r < 12) begin
         rq = frame(o[0], nx, ny, 1'($urandom_range(0, 1)), 1'b0);
      end else if (r < 16) begin
         nx = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 40))
                                   : -32768 + int'($urandom_range(0, 40));
         ny = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 40))
                                   : -32768 + int'($urandom_range(0, 40));
         rq = frame(o[0], nx, ny, $urandom_range(0, 3) == 0, 1'b1);
      end else begin
         rq = frame(o[0], nx, ny, $urandom_range(0, 5) == 0, 1'b1);
      end
      last_sim_x[o] = int'($signed(rq.sim_x));
      last_sim_y[o] = int'($signed(rq.sim_y));
      return rq;
   endfunction

   // Offer one request and wait until it is taken
   task automatic send_request(item_type rq);
      req_valid           <= 1'b1;
      req_object_index    <= rq.object_index;
      req_sim_x           <= rq.sim_x;
      req_sim_y           <= rq.sim_y;
      req_correction_done <= rq.correction_done;
      req_active          <= rq.active;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(rq);
   endtask

   task automatic pause_sender();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic drain();
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write all three control registers on consecutive cycles
   task automatic configure(logic [KEEP_W-1:0] k, logic [SNAP_W-1:0] s,
                            logic [ZERO_W-1:0] z);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_KEEP_FACTOR;
      csr_write_data   <= CSR_DATA_W'(k);
      @(posedge clock);
      csr_index        <= CSR_SNAP_THRESHOLD;
      csr_write_data   <= CSR_DATA_W'(s);
      @(posedge clock);
      csr_index        <= CSR_ZERO_THRESHOLD;
      csr_write_data   <= CSR_DATA_W'(z);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_config(k, s, z);
   endtask

   // Stimulus
   initial begin
      sb                  = new();
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_KEEP_FACTOR;
      csr_write_data      = '0;
      req_valid           = 1'b0;
      req_object_index    = 1'b0;
      req_sim_x           = '0;
      req_sim_y           = '0;
      req_correction_done = 1'b0;
      req_active          = 1'b0;
      foreach (last_sim_x[i]) begin
         last_sim_x[i] = 0;
         last_sim_y[i] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default registers: init, seed, decay down to the zero threshold, snap
      send_request(frame(1'b0, 100, 200, 1'b0, 1'b1));
      send_request(frame(1'b0, 90, 210, 1'b1, 1'b1));
      repeat (7) send_request(frame(1'b0, 90, 210, 1'b0, 1'b1));
      send_request(frame(1'b0, 400, 210, 1'b1, 1'b1));
      send_request(frame(1'b0, -32768, 32767, 1'b1, 1'b0));
      // first active frame with the correction flag, then clamp at the edges
      send_request(frame(1'b1, 32767, -32768, 1'b1, 1'b1));
      send_request(frame(1'b1, 32667, -32668, 1'b1, 1'b1));
      send_request(frame(1'b1, 32767, -32768, 1'b0, 1'b1));
      send_request(frame(1'b1, 32767, -32768, 1'b1, 1'b1));
      req_valid <= 1'b0;
      drain();

      // widest snap window: seeded offsets saturate both ways
      configure(16'hFFFF, 15'h7FFF, 16'h0000);
      send_request(frame(1'b0, 0, 0, 1'b0, 1'b0));
      send_request(frame(1'b0, -1000, 2000, 1'b1, 1'b1));
      repeat (2) send_request(frame(1'b0, -1000, 2000, 1'b0, 1'b1));
      send_request(frame(1'b1, 100, -100, 1'b0, 1'b0));
      send_request(frame(1'b1, 800, -100, 1'b1, 1'b1));
      send_request(frame(1'b1, -32768, 32767, 1'b1, 1'b1));
      req_valid <= 1'b0;
      drain();

      // random phases, one register setting each
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: configure(KEEP_RESET, SNAP_RESET, ZERO_RESET);
            1: configure(16'hFFFF, 15'h7FFF, 16'h0000);
            2: configure(16'h0000, 15'h0000, 16'hFFFF);
            3: configure(KEEP_W'($urandom_range(0, 65535)),
                         SNAP_W'($urandom_range(0, 32767)),
                         ZERO_W'($urandom_range(0, 512)));
            4: configure(16'd52000, 15'd600, 16'd16);
            5: configure(KEEP_W'($urandom_range(0, 65535)),
                         SNAP_W'($urandom_range(0, 32767)),
                         ZERO_W'($urandom_range(0, 65535)));
            6: configure(16'hFFFF, 15'd1000, 16'd1);
            default: configure(KEEP_W'($urandom_range(0, 65535)), 15'h7FFF, ZERO_RESET);
         endcase
         idle_on = (p < NUM_PHASES - 2);
         if (p == 1) long_hold = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_request(random_frame());
            pause_sender();
         end
         req_valid <= 1'b0;
         drain();
      end

      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("PASS rollback_offset_smoother");
      end else begin
         $display("FAIL rollback_offset_smoother");
      end
      $finish;
   end

   // Result sink with random stalls and one long hold
   initial begin : response_sink
      int unsigned stall_left;
      result_type  got;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.screen_x     = rsp_screen_x;
            got.screen_y     = rsp_screen_y;
            got.smoothing_on = rsp_smoothing_on;
            sb.check_result(got);
         end
         if (long_hold) begin
            long_hold  = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 15);
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run after too many cycles without a handshake
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAIL rollback_offset_smoother");
      $finish;
   end

endmodule

FILE: rollback_offset_smoother.f
rtl/rbos_pkg.sv
rtl/rbos_csr.sv
rtl/rbos_datapath.sv
rtl/rollback_offset_smoother.sv
tb/sv/smoother_scoreboard_pkg.sv
tb/sv/testbench.sv
